### src/stack_machine_executor_macros.svh
// ---------------------------------------------------------------------------
// stack machine executor assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ---------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// same-cycle implication
`define SMX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/smx_pkg.sv
// ---------------------------------------------------------------------------
// smx_pkg
// shared types and constants of the stack machine executor
// ---------------------------------------------------------------------------
package smx_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int FUNC_WIDTH      = 5;
  localparam int PC_WIDTH        = 10;
  localparam int CODE_WORDS      = 1024;
  localparam int DEPTH_WIDTH     = 9;
  localparam int STATUS_WIDTH    = 3;
  localparam int DEF_STACK_DEPTH = 256;
  localparam int DEF_NUM_VARS    = 128;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [FUNC_WIDTH-1:0] {
    OP_IMM   = 5'd0,
    OP_LOAD  = 5'd1,
    OP_SAVE  = 5'd2,
    OP_ADD   = 5'd3,
    OP_SUB   = 5'd4,
    OP_MUL   = 5'd5,
    OP_DIV   = 5'd6,
    OP_LT    = 5'd7,
    OP_GT    = 5'd8,
    OP_EQ    = 5'd9,
    OP_JZ    = 5'd10,
    OP_JMP   = 5'd11,
    OP_END   = 5'd12
  } op_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK          = 3'd0,
    ST_UNDERFLOW   = 3'd1,
    ST_OVERFLOW    = 3'd2,
    ST_DIV_ZERO    = 3'd3,
    ST_BAD_INDEX   = 3'd4,
    ST_BAD_TARGET  = 3'd5,
    ST_UNSUPPORTED = 3'd6
  } status_t;

endpackage

### src/stack_machine_executor.sv
// ---------------------------------------------------------------------------
// stack_machine_executor
// executes one stack-machine instruction per input transaction
// ---------------------------------------------------------------------------
// Each input transaction (func, arg) runs one instruction against an operand
// stack, a variable file, a program counter and a halt flag, and gives one
// result transaction with the state after the step. One instruction at a
// time: an instruction passes decode and check, execute and result load
// before its result is registered; a divide waits in between for the
// bit-serial divider. A new instruction is taken once the previous one has
// reached the result register, which waits while out_stall holds the last
// result. Errors, the end instruction and a program counter that runs past
// the code halt the block until reset; while halted every instruction
// reports the current state with status ok. The operand stack is a memory
// read one entry per instruction in the check step with the top of stack
// held in a register; the variable file reads zero until an entry is
// written, so no clearing pass is needed after reset.
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int NUM_VARS    = DEF_NUM_VARS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [FUNC_WIDTH-1:0]   func,
  input  logic signed [31:0]      arg,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PC_WIDTH-1:0]     next_pc,
  output logic signed [31:0]      top_value,
  output logic [DEPTH_WIDTH-1:0]  stack_depth,
  output logic                    halted,
  output logic [STATUS_WIDTH-1:0] status
);

`include "stack_machine_executor_macros.svh"

  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int VW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state;
  logic [FUNC_WIDTH-1:0]   func_reg;
  logic [31:0]             arg_reg;
  logic [SPW-1:0]          sp;
  data_t                   top;
  logic [PC_WIDTH-1:0]     pc;
  logic                    halt_flag;
  status_t                 status_reg;

  // operand stack below the top register, undefined until written
  data_t                   st_mem [STACK_DEPTH];
  data_t                   st_rdata;
  // variable file, entries read as zero until written
  data_t                   var_mem [NUM_VARS];
  logic [NUM_VARS-1:0]     var_valid;
  data_t                   var_rdata;
  logic                    var_hit;

  logic [SPW-1:0]          sp_m1;
  logic [SPW-1:0]          sp_m2;
  logic [VW-1:0]           var_idx;
  status_t                 chk_status;
  logic                    is_binary;
  logic                    top_zero;
  logic                    push_op;
  logic                    st_we;
  logic                    var_we;
  logic                    jump_taken;
  logic [PC_WIDTH:0]       npc;
  logic                    wrap;
  data_t                   alu_result;
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  data_t                   div_q;

  assign in_stall  = (state != S_IDLE);
  assign sp_m1     = sp - SPW'(1);
  assign sp_m2     = sp - SPW'(2);
  assign var_idx   = arg_reg[VW-1:0];
  assign is_binary = (func_reg >= OP_ADD) && (func_reg <= OP_EQ);
  assign top_zero  = (top == '0);
  assign push_op   = (func_reg == OP_IMM) || (func_reg == OP_LOAD);

  // error checks, in priority order: underflow, overflow, divide by zero,
  // bad index, bad target, unsupported
  always_comb begin
    chk_status = ST_OK;
    if ((func_reg == OP_SAVE) || (func_reg == OP_JZ)) begin
      if (sp == '0) chk_status = ST_UNDERFLOW;
    end else if (push_op) begin
      if (sp >= SPW'(STACK_DEPTH)) chk_status = ST_OVERFLOW;
    end else if (is_binary) begin
      if (sp < SPW'(2)) chk_status = ST_UNDERFLOW;
      else if ((func_reg == OP_DIV) && top_zero) chk_status = ST_DIV_ZERO;
    end else if (func_reg > OP_END) begin
      chk_status = ST_UNSUPPORTED;
    end
    if ((chk_status == ST_OK) && ((func_reg == OP_LOAD) || (func_reg == OP_SAVE))
        && (arg_reg >= 32'(NUM_VARS)))
      chk_status = ST_BAD_INDEX;
    if ((chk_status == ST_OK) && (arg_reg >= 32'(CODE_WORDS))
        && (((func_reg == OP_JZ) && top_zero) || (func_reg == OP_JMP)))
      chk_status = ST_BAD_TARGET;
  end

  // next program counter: advance by two, jump, or hold on end; running past the code wraps and halts
  assign jump_taken = (func_reg == OP_JMP) || ((func_reg == OP_JZ) && top_zero);
  always_comb begin
    if (func_reg == OP_END)
      npc = {1'b0, pc};
    else if (jump_taken)
      npc = {1'b0, arg_reg[PC_WIDTH-1:0]};
    else
      npc = {1'b0, pc} + (PC_WIDTH + 1)'(2);
  end
  assign wrap = (func_reg != OP_END) && (npc >= (PC_WIDTH + 1)'(CODE_WORDS));

  assign st_we     = (state == S_EXEC) && push_op && (sp != '0);
  assign var_we    = (state == S_EXEC) && (func_reg == OP_SAVE);
  assign div_start = (state == S_EXEC) && (func_reg == OP_DIV);

  smx_alu u_alu (
    .func   (func_reg),
    .a      (st_rdata),
    .b      (top),
    .result (alu_result)
  );

  smx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (st_rdata),
    .b     (top),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  // stack memory: written on push of the old top, read of the entry below
  // the top during the check cycle
  always_ff @(posedge clk) begin
    if (st_we) st_mem[sp_m1[SW-1:0]] <= top;
    if (state == S_CHECK) st_rdata <= st_mem[sp_m2[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (var_we) var_mem[var_idx] <= top;
    if (state == S_CHECK) begin
      var_rdata <= var_mem[var_idx];
      var_hit   <= var_valid[var_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      pc        <= '0;
      halt_flag <= 1'b0;
      var_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register reloads in S_DONE, otherwise it empties when taken
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_reg <= func;
            arg_reg  <= arg;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (halt_flag) begin
            status_reg <= ST_OK;
            state      <= S_DONE;
          end else if (chk_status != ST_OK) begin
            status_reg <= chk_status;
            halt_flag  <= 1'b1;
            state      <= S_DONE;
          end else begin
            status_reg <= ST_OK;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= (func_reg == OP_DIV) ? S_DIV : S_DONE;
          case (func_reg)
            OP_IMM: begin
              top <= arg_reg;
              sp  <= sp + SPW'(1);
            end
            OP_LOAD: begin
              top <= var_hit ? var_rdata : '0;
              sp  <= sp + SPW'(1);
            end
            OP_SAVE: begin
              var_valid[var_idx] <= 1'b1;
              top <= st_rdata;
              sp  <= sp_m1;
            end
            OP_JZ: begin
              top <= st_rdata;
              sp  <= sp_m1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_GT, OP_EQ: begin
              top <= alu_result;
              sp  <= sp_m1;
            end
            default: begin
            end
          endcase
          pc <= wrap ? PC_WIDTH'(npc - (PC_WIDTH + 1)'(CODE_WORDS)) : npc[PC_WIDTH-1:0];
          if (wrap || (func_reg == OP_END)) halt_flag <= 1'b1;
        end
        S_DIV: begin
          if (div_done) begin
            top   <= div_q;
            sp    <= sp_m1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // result register frees as the previous transaction is taken
          if (!out_valid || !out_stall) begin
            next_pc     <= pc;
            top_value   <= (sp != '0) ? top : '0;
            stack_depth <= DEPTH_WIDTH'(sp);
            halted      <= halt_flag;
            status      <= status_reg;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the halt flag only leaves through reset
  `SMX_ASSERT_NEXT(a_halt_sticky, halt_flag, halt_flag, "halt flag dropped")
  // an error status always comes with the halt flag
  `SMX_ASSERT_SAME(a_err_halts, out_valid && (status != ST_OK), halted, "error without halt")
  // stack pointer stays within the stack
  `SMX_ASSERT_SAME(a_sp_range, 1'b1, sp <= SPW'(STACK_DEPTH), "stack pointer out of range")
  // divider runs only while the sequencer waits for it
  `SMX_ASSERT_SAME(a_div_owned, div_busy, state == S_DIV, "divider busy outside divide wait")

endmodule

### src/smx_alu.sv
// ---------------------------------------------------------------------------
// smx_alu
// shared add, subtract, multiply and signed compare unit
// ---------------------------------------------------------------------------
module smx_alu
  import smx_pkg::*;
(
  input  logic [FUNC_WIDTH-1:0] func,
  input  data_t                 a,
  input  data_t                 b,
  output data_t                 result
);

  always_comb begin
    case (func)
      OP_ADD:  result = a + b;
      OP_SUB:  result = a - b;
      OP_MUL:  result = a * b;
      OP_LT:   result = data_t'($signed(a) < $signed(b));
      OP_GT:   result = data_t'($signed(a) > $signed(b));
      OP_EQ:   result = data_t'(a == b);
      default: result = '0;
    endcase
  end

endmodule

### src/smx_div.sv
// ---------------------------------------------------------------------------
// smx_div
// bit-serial signed divider, truncating toward zero, one quotient bit a cycle
// ---------------------------------------------------------------------------
module smx_div
  import smx_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  data_t a,
  input  data_t b,
  output logic  busy,
  output logic  done,
  output data_t q
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH:0]   rem;
  data_t                 quo;
  data_t                 divisor;
  logic                  neg;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;

  assign rem_sh = {rem[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign q      = neg ? (~quo + data_t'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        count   <= CW'(DATA_WIDTH);
        rem     <= '0;
        quo     <= a[DATA_WIDTH-1] ? (~a + data_t'(1)) : a;
        divisor <= b[DATA_WIDTH-1] ? (~b + data_t'(1)) : b;
        neg     <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      end else if (busy) begin
        if (!diff[DATA_WIDTH]) begin
          rem <= diff;
          quo <= {quo[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DATA_WIDTH-2:0], 1'b0};
        end
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
